/* hdl/runtime_clock_display_multiplexer_defines.svh */
// ----------------------------------------------------------------------------
// Runtime clock display multiplexer: assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RUNTIME_CLOCK_DISPLAY_MULTIPLEXER_DEFINES_SVH
`define RUNTIME_CLOCK_DISPLAY_MULTIPLEXER_DEFINES_SVH

`ifndef SYNTHESIS

// check that cond holds at every edge
`define RCDM_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check that cons holds in the same cycle as ante
`define RCDM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that cons holds in the cycle after ante
`define RCDM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RCDM_ASSERT(name, cond, msg)
`define RCDM_ASSERT_IMPL(name, ante, cons, msg)
`define RCDM_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

/* hdl/rcdm_pkg.sv */
// ----------------------------------------------------------------------------
// rcdm_pkg
// Shared widths, reset values, codes and lookup functions of the display mux.
// ----------------------------------------------------------------------------
package rcdm_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int POS_W      = 3;
  localparam int TPS_W      = 10;
  localparam int HOUR_W     = 7;
  localparam int MIN_W      = 6;
  localparam int SEC_W      = 6;
  localparam int DIGIT_W    = 4;
  localparam int EN_W       = 4;
  localparam int SEG_W      = 8;

  localparam logic [TPS_W-1:0]  TPS_RESET       = 10'd119;
  localparam logic [HOUR_W-1:0] HOUR_WRAP_RESET = 7'd99;
  localparam logic [HOUR_W-1:0] HOUR_LIMIT_MAX  = 7'd99;
  localparam logic [SEC_W-1:0]  SEC_WRAP        = 6'd60;
  localparam logic [MIN_W-1:0]  MIN_WRAP        = 6'd60;
  localparam logic [SEG_W-1:0]  SEG_DASH        = 8'hDF;
  localparam logic [EN_W-1:0]   ENABLE_OFF      = 4'hF;

  localparam logic [POS_W-1:0] POS_IDLE   = 3'd0;
  localparam logic [POS_W-1:0] POS_H_TENS = 3'd1;
  localparam logic [POS_W-1:0] POS_H_UNIT = 3'd2;
  localparam logic [POS_W-1:0] POS_M_TENS = 3'd3;
  localparam logic [POS_W-1:0] POS_M_UNIT = 3'd4;
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(NUM_DIGITS);

  // register select is paddr[2]
  localparam logic REG_TPS       = 1'b0;
  localparam logic REG_HOUR_WRAP = 1'b1;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } clock_time_t;

  // active-low segments, bit order edhcgbfa
  function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h28;
      4'd1:    s = 8'hEB;
      4'd2:    s = 8'h32;
      4'd3:    s = 8'hA2;
      4'd4:    s = 8'hE1;
      4'd5:    s = 8'hA4;
      4'd6:    s = 8'h24;
      4'd7:    s = 8'hEA;
      4'd8:    s = 8'h20;
      default: s = 8'hA0;
    endcase
    return s;
  endfunction

  function automatic logic [EN_W-1:0] enable_code(input logic [POS_W-1:0] p);
    logic [EN_W-1:0] e;
    unique case (p)
      POS_H_TENS: e = 4'hD;
      POS_H_UNIT: e = 4'hE;
      POS_M_TENS: e = 4'hB;
      POS_M_UNIT: e = 4'h7;
      default:    e = ENABLE_OFF;
    endcase
    return e;
  endfunction

  // tens digit by reciprocal multiply, exact below 1029
  function automatic logic [DIGIT_W-1:0] tens_of(input logic [HOUR_W-1:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return DIGIT_W'(p >> 11);
  endfunction

  function automatic logic [DIGIT_W-1:0] units_of(input logic [HOUR_W-1:0] x);
    logic [HOUR_W-1:0] t;
    t = HOUR_W'(tens_of(x)) * 7'd10;
    return DIGIT_W'(x - t);
  endfunction

endpackage

/* hdl/runtime_clock_display_multiplexer.sv */
// ----------------------------------------------------------------------------
// runtime_clock_display_multiplexer
// Four-digit multiplexed display of an elapsed hours:minutes clock.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_tick
//   out     | output    | out_valid / out_ready | enables, segments, position, time
//   cfg     | input     | psel/penable/pready   | ticks_per_second, hour_wrap
//
// One tick is taken per cycle while in_ready is high; its result is registered and
// shows in the next cycle. The display and clock registers are the result register.
// in_ready drops only while a result waits and out_ready is low.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`include "runtime_clock_display_multiplexer_defines.svh"

module runtime_clock_display_multiplexer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_tick,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcdm_pkg::EN_W-1:0]         out_digit_enable_n,
  output logic [rcdm_pkg::SEG_W-1:0]        out_segments_n,
  output logic                              out_segments_valid,
  output logic [rcdm_pkg::POS_W-1:0]        out_position,
  output logic [rcdm_pkg::HOUR_W-1:0]       out_hours_now,
  output logic [rcdm_pkg::MIN_W-1:0]        out_minutes_now,
  output logic [rcdm_pkg::SEC_W-1:0]        out_seconds_now,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic                              accept, step, advance, cfg_wr;
  logic [rcdm_pkg::TPS_W-1:0]        tps_r;
  logic [rcdm_pkg::HOUR_W-1:0]       hour_wrap_r;
  logic [rcdm_pkg::POS_W-1:0]        pos_r, pos_nxt, served_r, served_nxt;
  logic [rcdm_pkg::EN_W-1:0]         en_r, en_nxt;
  logic [rcdm_pkg::SEG_W-1:0]        seg_r, seg_nxt, seg_digit;
  logic                              seg_valid_r, seg_valid_nxt, out_valid_r;
  rcdm_pkg::clock_time_t             now;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign step     = accept && in_tick;
  assign advance  = step && (pos_r == rcdm_pkg::POS_H_TENS);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= rcdm_pkg::TPS_RESET;
      hour_wrap_r <= rcdm_pkg::HOUR_WRAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rcdm_pkg::REG_TPS:       tps_r       <= pwdata[rcdm_pkg::TPS_W-1:0];
        rcdm_pkg::REG_HOUR_WRAP: hour_wrap_r <= pwdata[rcdm_pkg::HOUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rcdm_pkg::REG_TPS:       prdata = 32'(tps_r);
      rcdm_pkg::REG_HOUR_WRAP: prdata = 32'(hour_wrap_r);
      default:                 prdata = '0;
    endcase
  end

  rcdm_time u_time (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .ticks_per_second (tps_r),
    .hour_wrap        (hour_wrap_r),
    .now              (now)
  );

  rcdm_digit u_digit (
    .pos        (pos_r),
    .now        (now),
    .segments_n (seg_digit)
  );

  // on a tick, serve the current position and advance it; otherwise report the last served one
  always_comb begin
    pos_nxt       = pos_r;
    en_nxt        = en_r;
    seg_nxt       = seg_r;
    seg_valid_nxt = 1'b0;
    served_nxt    = pos_r;
    if (in_tick) begin
      if (pos_r != rcdm_pkg::POS_IDLE) begin
        en_nxt        = rcdm_pkg::enable_code(pos_r);
        seg_nxt       = seg_digit;
        seg_valid_nxt = 1'b1;
      end
      pos_nxt = (pos_r == rcdm_pkg::POS_LAST || pos_r == rcdm_pkg::POS_IDLE) ?
                rcdm_pkg::POS_H_TENS : pos_r + 1'b1;
    end else if (en_r == rcdm_pkg::ENABLE_OFF) begin
      served_nxt = rcdm_pkg::POS_IDLE;
    end else if (pos_r <= rcdm_pkg::POS_H_TENS) begin
      served_nxt = rcdm_pkg::POS_LAST;
    end else begin
      served_nxt = pos_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= rcdm_pkg::POS_IDLE;
      en_r        <= rcdm_pkg::ENABLE_OFF;
      seg_r       <= rcdm_pkg::SEG_DASH;
      seg_valid_r <= 1'b0;
      served_r    <= rcdm_pkg::POS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r       <= pos_nxt;
        en_r        <= en_nxt;
        seg_r       <= seg_nxt;
        seg_valid_r <= seg_valid_nxt;
        served_r    <= served_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit_enable_n = en_r;
  assign out_segments_n     = seg_r;
  assign out_segments_valid = seg_valid_r;
  assign out_position       = served_r;
  assign out_hours_now      = now.hours;
  assign out_minutes_now    = now.minutes;
  assign out_seconds_now    = now.seconds;

  `RCDM_ASSERT_NEXT(a_time_holds_when_idle, !accept, $stable(now), "clock moved without a tick")
  `RCDM_ASSERT_NEXT(a_idle_tick_sends_nothing, step && pos_r == rcdm_pkg::POS_IDLE, !out_segments_valid && out_position == rcdm_pkg::POS_IDLE, "idle position sent a digit")
  `RCDM_ASSERT_IMPL(a_sent_digit_enabled, out_valid_r && out_segments_valid, out_digit_enable_n != rcdm_pkg::ENABLE_OFF, "segment byte sent with all digits off")
  `RCDM_ASSERT(a_time_in_range, now.seconds < rcdm_pkg::SEC_WRAP && now.minutes < rcdm_pkg::MIN_WRAP && now.hours < rcdm_pkg::HOUR_LIMIT_MAX, "clock value out of range")

endmodule

/* hdl/rcdm_time.sv */
// ----------------------------------------------------------------------------
// rcdm_time
// Sub-second, second, minute and hour counters with configurable sub-second and hour rollover.
// ----------------------------------------------------------------------------
module rcdm_time (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             advance,
  input  logic [rcdm_pkg::TPS_W-1:0]       ticks_per_second,
  input  logic [rcdm_pkg::HOUR_W-1:0]      hour_wrap,
  output rcdm_pkg::clock_time_t            now
);

  logic [rcdm_pkg::TPS_W-1:0]  sub_r, sub_nxt, sub_inc;
  logic [rcdm_pkg::SEC_W-1:0]  sec_r, sec_nxt, sec_inc;
  logic [rcdm_pkg::MIN_W-1:0]  min_r, min_nxt, min_inc;
  logic [rcdm_pkg::HOUR_W-1:0] hour_r, hour_nxt, hour_inc, hour_lim;

  always_comb begin
    sub_inc  = sub_r + 1'b1;
    sec_inc  = sec_r + 1'b1;
    min_inc  = min_r + 1'b1;
    hour_inc = hour_r + 1'b1;
    hour_lim = (hour_wrap > rcdm_pkg::HOUR_LIMIT_MAX) ? rcdm_pkg::HOUR_LIMIT_MAX : hour_wrap;

    sub_nxt  = sub_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;

    if (advance) begin
      sub_nxt = sub_inc;
      if (sub_inc >= ticks_per_second) begin
        sub_nxt = '0;
        sec_nxt = sec_inc;
        if (sec_inc >= rcdm_pkg::SEC_WRAP) begin
          sec_nxt = '0;
          min_nxt = min_inc;
          if (min_inc >= rcdm_pkg::MIN_WRAP) begin
            min_nxt  = '0;
            hour_nxt = (hour_inc >= hour_lim) ? '0 : hour_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r  <= '0;
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
    end else begin
      sub_r  <= sub_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
    end
  end

  assign now.hours   = hour_r;
  assign now.minutes = min_r;
  assign now.seconds = sec_r;

endmodule

/* hdl/rcdm_digit.sv */
// ----------------------------------------------------------------------------
// rcdm_digit
// Pick the decimal digit of hours*100+minutes for a position and encode it.
// ----------------------------------------------------------------------------
module rcdm_digit (
  input  logic [rcdm_pkg::POS_W-1:0] pos,
  input  rcdm_pkg::clock_time_t      now,
  output logic [rcdm_pkg::SEG_W-1:0] segments_n
);

  logic [rcdm_pkg::DIGIT_W-1:0] digit;
  logic [rcdm_pkg::HOUR_W-1:0]  minutes_ext;

  assign minutes_ext = rcdm_pkg::HOUR_W'(now.minutes);

  always_comb begin
    unique case (pos)
      rcdm_pkg::POS_H_TENS: digit = rcdm_pkg::tens_of(now.hours);
      rcdm_pkg::POS_H_UNIT: digit = rcdm_pkg::units_of(now.hours);
      rcdm_pkg::POS_M_TENS: digit = rcdm_pkg::tens_of(minutes_ext);
      default:              digit = rcdm_pkg::units_of(minutes_ext);
    endcase
  end

  assign segments_n = rcdm_pkg::seg_code(digit);

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: runtime clock display multiplexer testbench
// Drives refresh ticks through the valid/ready input, predicts every display
// word (digit enables, segments, position, elapsed time) in a scoreboard and
// compares each accepted word field by field. Runs several register settings,
// random idling on both sides, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_TPS       = 3'd0;
  localparam logic [2:0] ADDR_HOUR_WRAP = 3'd4;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [rcdm_pkg::EN_W-1:0]   en;
    logic [rcdm_pkg::SEG_W-1:0]  seg;
    logic                        sv;
    logic [rcdm_pkg::POS_W-1:0]  pos;
    logic [rcdm_pkg::HOUR_W-1:0] hrs;
    logic [rcdm_pkg::MIN_W-1:0]  mins;
    logic [rcdm_pkg::SEC_W-1:0]  secs;
  } display_word_t;

  class display_scoreboard;
    bit [rcdm_pkg::TPS_W-1:0]  tps;
    bit [rcdm_pkg::HOUR_W-1:0] hwrap;
    bit [rcdm_pkg::POS_W-1:0]  dpos;
    bit [rcdm_pkg::TPS_W-1:0]  sub;
    bit [rcdm_pkg::SEC_W-1:0]  secs;
    bit [rcdm_pkg::MIN_W-1:0]  mins;
    bit [rcdm_pkg::HOUR_W-1:0] hrs;
    bit [rcdm_pkg::EN_W-1:0]   en;
    bit [rcdm_pkg::SEG_W-1:0]  seg;
    display_word_t             pending_words[$];
    int errors, ticks, words, hour_wraps, max_hours;

    function new();
      tps = rcdm_pkg::TPS_RESET;
      hwrap = rcdm_pkg::HOUR_WRAP_RESET;
      dpos = rcdm_pkg::POS_IDLE;
      sub = '0;
      secs = '0;
      mins = '0;
      hrs = '0;
      en = rcdm_pkg::ENABLE_OFF;
      seg = rcdm_pkg::SEG_DASH;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function bit [rcdm_pkg::SEG_W-1:0] glyph(int d);
      bit [rcdm_pkg::SEG_W-1:0] s;
      case (d)
        0:       s = 8'h28;
        1:       s = 8'hEB;
        2:       s = 8'h32;
        3:       s = 8'hA2;
        4:       s = 8'hE1;
        5:       s = 8'hA4;
        6:       s = 8'h24;
        7:       s = 8'hEA;
        8:       s = 8'h20;
        default: s = 8'hA0;
      endcase
      return s;
    endfunction

    function bit [rcdm_pkg::EN_W-1:0] lit_code(bit [rcdm_pkg::POS_W-1:0] p);
      bit [rcdm_pkg::EN_W-1:0] e;
      case (p)
        rcdm_pkg::POS_H_TENS: e = 4'hD;
        rcdm_pkg::POS_H_UNIT: e = 4'hE;
        rcdm_pkg::POS_M_TENS: e = 4'hB;
        default:              e = 4'h7;
      endcase
      return e;
    endfunction

    function int digit_at(bit [rcdm_pkg::POS_W-1:0] p);
      int v, d;
      v = int'(hrs) * 100 + int'(mins);
      case (p)
        rcdm_pkg::POS_H_TENS: d = v / 1000;
        rcdm_pkg::POS_H_UNIT: d = (v % 1000) / 100;
        rcdm_pkg::POS_M_TENS: d = (v % 100) / 10;
        default:              d = v % 10;
      endcase
      if (d > 9) d = 9;
      return d;
    endfunction

    function void advance_time();
      bit [rcdm_pkg::HOUR_W-1:0] lim;
      sub = sub + 1'b1;
      if (sub < tps) return;
      sub = '0;
      secs = secs + 1'b1;
      if (secs < rcdm_pkg::SEC_WRAP) return;
      secs = '0;
      mins = mins + 1'b1;
      if (mins < rcdm_pkg::MIN_WRAP) return;
      mins = '0;
      lim = (hwrap > rcdm_pkg::HOUR_LIMIT_MAX) ? rcdm_pkg::HOUR_LIMIT_MAX : hwrap;
      hrs = hrs + 1'b1;
      if (hrs >= lim) begin
        hrs = '0;
        hour_wraps++;
      end
      if (int'(hrs) > max_hours) max_hours = int'(hrs);
    endfunction

    function void note_tick(bit t);
      display_word_t w;
      bit [rcdm_pkg::POS_W-1:0] served;
      bit sv;
      sv = 1'b0;
      if (t) begin
        served = dpos;
        if (served >= rcdm_pkg::POS_H_TENS && served <= rcdm_pkg::POS_LAST) begin
          en = lit_code(served);
          seg = glyph(digit_at(served));
          sv = 1'b1;
          if (served == rcdm_pkg::POS_H_TENS) advance_time();
        end else begin
          served = rcdm_pkg::POS_IDLE;
        end
        dpos = dpos + 1'b1;
        if (dpos > rcdm_pkg::POS_LAST || dpos == rcdm_pkg::POS_IDLE) begin
          dpos = rcdm_pkg::POS_H_TENS;
        end
      end else begin
        if (en == rcdm_pkg::ENABLE_OFF) served = rcdm_pkg::POS_IDLE;
        else if (dpos <= rcdm_pkg::POS_H_TENS) served = rcdm_pkg::POS_LAST;
        else served = dpos - 1'b1;
      end
      w.en = en;
      w.seg = seg;
      w.sv = sv;
      w.pos = served;
      w.hrs = hrs;
      w.mins = mins;
      w.secs = secs;
      pending_words.push_back(w);
      ticks++;
    endfunction

    function void cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(display_word_t got);
      display_word_t w;
      if (pending_words.size() == 0) begin
        $error("display word with no pending tick");
        errors++;
        return;
      end
      w = pending_words.pop_front();
      words++;
      cmp("digit_enable_n", int'(w.en), int'(got.en));
      cmp("segments_n", int'(w.seg), int'(got.seg));
      cmp("segments_valid", int'(w.sv), int'(got.sv));
      cmp("position", int'(w.pos), int'(got.pos));
      cmp("hours_now", int'(w.hrs), int'(got.hrs));
      cmp("minutes_now", int'(w.mins), int'(got.mins));
      cmp("seconds_now", int'(w.secs), int'(got.secs));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_ready, in_tick;
  logic out_valid, out_ready;
  logic [rcdm_pkg::EN_W-1:0]   out_digit_enable_n;
  logic [rcdm_pkg::SEG_W-1:0]  out_segments_n;
  logic                        out_segments_valid;
  logic [rcdm_pkg::POS_W-1:0]  out_position;
  logic [rcdm_pkg::HOUR_W-1:0] out_hours_now;
  logic [rcdm_pkg::MIN_W-1:0]  out_minutes_now;
  logic [rcdm_pkg::SEC_W-1:0]  out_seconds_now;
  logic psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  display_scoreboard sb = new();
  int in_idle_pct = 29;
  int out_idle_pct = 29;
  bit stall_req = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  int settings = 0;

  runtime_clock_display_multiplexer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_tick(in_tick),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digit_enable_n(out_digit_enable_n), .out_segments_n(out_segments_n),
    .out_segments_valid(out_segments_valid), .out_position(out_position),
    .out_hours_now(out_hours_now), .out_minutes_now(out_minutes_now),
    .out_seconds_now(out_seconds_now),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    display_word_t got;
    bit active;
    active = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_tick(in_tick);
        active = 1'b1;
      end
      if (out_valid && out_ready) begin
        got.en = out_digit_enable_n;
        got.seg = out_segments_n;
        got.sv = out_segments_valid;
        got.pos = out_position;
        got.hrs = out_hours_now;
        got.mins = out_minutes_now;
        got.secs = out_seconds_now;
        sb.check_word(got);
        active = 1'b1;
      end
      if (psel) active = 1'b1;
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic drive_tick(input bit t);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.cmp("prdata", value, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int tps, input int hw, input int n, input int tick_pct,
                           input bit calm, input bit pressure);
    drain();
    write_reg(ADDR_TPS, tps);
    sb.tps = rcdm_pkg::TPS_W'(tps);
    write_reg(ADDR_HOUR_WRAP, hw);
    sb.hwrap = rcdm_pkg::HOUR_W'(hw);
    settings++;
    in_idle_pct = calm ? 0 : 29;
    out_idle_pct = calm ? 0 : 29;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == n / 4) stall_req = 1'b1;
      if (pressure && i == n / 2) drain();
      drive_tick($urandom_range(99) < tick_pct);
    end
  endtask

  initial begin
    bit [19:0] directed;
    directed = 20'b0101_1110_1011_0111_0011;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_tick = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: no tick before anything, idle position, all four digits
    for (int i = 19; i >= 0; i--) drive_tick(directed[i]);
    run_phase(int'(rcdm_pkg::TPS_RESET), int'(rcdm_pkg::HOUR_WRAP_RESET), 300, 80,
              1'b0, 1'b0);
    // fastest seconds, minute rollovers, hour limit of two
    run_phase(1, 2, 700, 85, 1'b0, 1'b0);
    // zero compare and zero hour limit
    run_phase(0, 0, 400, 85, 1'b0, 1'b0);
    // upper extremes, no idling
    run_phase(1023, 127, 200, 85, 1'b1, 1'b0);
    run_phase(5, 120, 300, 85, 1'b0, 1'b1);
    run_phase(2, 1, 100, 50, 1'b0, 1'b0);
    drain();

    $display("covered %0d ticks and %0d display words over %0d register settings",
             sb.ticks, sb.words, settings);
    $display("hours reached %0d, hour wraps seen %0d", sb.max_hours, sb.hour_wraps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
